### design/prr_pkg.sv
// Shared types, constants and helpers of the polar rate recovery block.
`default_nettype none
package prr_pkg;

  // Sizes of the codeword store
  localparam int MAX_N         = 512;
  localparam int ADDR_W        = $clog2(MAX_N);
  localparam int N_W           = ADDR_W + 1;
  localparam int MAX_LOG2      = ADDR_W;
  localparam int SEG_NUM_LOG2  = 5;
  localparam int SEG_IDX_W     = SEG_NUM_LOG2;
  localparam int SEG_NUM       = 2 ** SEG_NUM_LOG2;

  // Field widths
  localparam int LLR_W         = 8;
  localparam int POS_W         = 10;
  localparam int PUSH_W        = 13;
  localparam logic [PUSH_W-1:0] PUSH_SAT = {PUSH_W{1'b1}};

  // Configuration register widths
  localparam int LOG2_W        = 4;
  localparam int E_W           = 14;
  localparam int K_W           = 10;
  localparam int PERM_LOW_W    = 60;
  localparam int PERM_MID_W    = 60;
  localparam int PERM_HIGH_W   = 40;
  localparam int PERM_W        = PERM_LOW_W + PERM_MID_W + PERM_HIGH_W;
  localparam int MAXLLR_W      = 7;
  localparam int CFG_DATA_W    = 60;
  localparam int CFG_IDX_W     = 3;

  // Puncture test: K * 64 < E * 29
  localparam int PUNCT_K_MUL   = 64;
  localparam int PUNCT_E_MUL   = 29;
  localparam int MUL_W         = 20;

  // Queue between front and back
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LEN_LOG2 = 3'd0,
    CFG_RATE_MATCHED   = 3'd1,
    CFG_INFO_LEN       = 3'd2,
    CFG_PERM_LOW       = 3'd3,
    CFG_PERM_MID       = 3'd4,
    CFG_PERM_HIGH      = 3'd5,
    CFG_MAX_LLR        = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_PULL = 1'b1
  } func_e;

  typedef struct packed {
    logic [LOG2_W-1:0]   block_len_log2;
    logic [E_W-1:0]      rate_matched_len;
    logic [K_W-1:0]      info_len;
    logic [PERM_W-1:0]   perm;
    logic [MAXLLR_W-1:0] max_llr;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    block_len_log2:   4'd9,
    rate_matched_len: 14'd1728,
    info_len:         10'd64,
    perm:             '0,
    max_llr:          7'd127
  };

  // One classified command: a store write or a position read
  typedef struct packed {
    logic              is_pull;
    logic [ADDR_W-1:0] addr;
    logic [LLR_W-1:0]  llr;   // push data, or fill value on a pull
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic clear_busy;
  } back_status_t;

  // Pick one 5-bit entry of the packed sub-block permutation
  function automatic logic [SEG_IDX_W-1:0] perm_entry(input logic [PERM_W-1:0] perm,
                                                      input logic [SEG_IDX_W-1:0] j);
    return perm[int'(j) * SEG_IDX_W +: SEG_IDX_W];
  endfunction

endpackage
`default_nettype wire

### design/prr_in_if.sv
// Input channel: one beat carries a push or a pull request.
`default_nettype none
interface prr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [prr_pkg::LLR_W-1:0]  llr_in;

  modport source (output valid, output func, output llr_in, input ready);
  modport sink   (input valid, input func, input llr_in, output ready);
endinterface
`default_nettype wire

### design/prr_out_if.sv
// Output channel: one beat carries one recovered LLR.
`default_nettype none
interface prr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [prr_pkg::LLR_W-1:0]  llr_out;
  logic [prr_pkg::POS_W-1:0]         position;
  logic                              last;

  modport source (output valid, output llr_out, output position, output last, input ready);
  modport sink   (input valid, input llr_out, input position, input last, output ready);
endinterface
`default_nettype wire

### design/prr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module prr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/prr_queue.sv
// Short command queue between the classifying front and the executing back.
`default_nettype none
module prr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  prr_pkg::cmd_t      push_cmd_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output prr_pkg::cmd_t      pop_cmd_o,
  output logic               valid_o
);

  prr_pkg::cmd_t                 entry_q [prr_pkg::QUEUE_DEPTH];
  logic [prr_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [prr_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [prr_pkg::QCNT_W-1:0]    count_q, count_d;
  logic                          do_push;
  logic                          do_pop;

  assign ready_o   = (count_q != prr_pkg::QCNT_W'(prr_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && ready_o;
  assign do_pop    = pop_i && valid_o;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == prr_pkg::QPTR_W'(prr_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + prr_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == prr_pkg::QPTR_W'(prr_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + prr_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + prr_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - prr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entries; no reset on payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

### design/prr_front.sv
// Front part: accepts beats, keeps the counters and turns each beat into a command.
`default_nettype none
module prr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  prr_pkg::cfg_t          cfg_i,
  input  prr_pkg::back_status_t  back_status_i,
  prr_in_if.sink                 in_i,
  input  wire logic              q_ready_i,
  output logic                   q_valid_o,
  output prr_pkg::cmd_t          q_cmd_o
);

  logic [prr_pkg::PUSH_W-1:0]    push_q, push_d;
  logic [prr_pkg::ADDR_W-1:0]    pull_q, pull_d;

  logic [prr_pkg::LOG2_W-1:0]    log2_c;
  logic [prr_pkg::LOG2_W-1:0]    shift_c;
  logic [prr_pkg::N_W-1:0]       n_c;
  logic [prr_pkg::ADDR_W-1:0]    seg_mask;
  logic [prr_pkg::MUL_W-1:0]     k_scaled;
  logic [prr_pkg::MUL_W-1:0]     e_scaled;
  logic                          puncture;
  logic                          take;
  logic [prr_pkg::E_W-1:0]       rm_pos;
  logic                          rm_in;
  logic [prr_pkg::ADDR_W-1:0]    rm_addr;
  logic [prr_pkg::SEG_IDX_W-1:0] seg_idx;
  logic [prr_pkg::SEG_IDX_W-1:0] perm_val;
  logic [prr_pkg::ADDR_W-1:0]    dst;
  logic [prr_pkg::ADDR_W-1:0]    pos;
  logic                          pos_last;
  logic [prr_pkg::LLR_W-1:0]     fill;
  logic                          accept;
  logic                          is_pull;

  // Clamp the block length to the supported range
  always_comb begin
    log2_c = cfg_i.block_len_log2;
    if (log2_c < prr_pkg::LOG2_W'(prr_pkg::SEG_NUM_LOG2)) begin
      log2_c = prr_pkg::LOG2_W'(prr_pkg::SEG_NUM_LOG2);
    end else if (log2_c > prr_pkg::LOG2_W'(prr_pkg::MAX_LOG2)) begin
      log2_c = prr_pkg::LOG2_W'(prr_pkg::MAX_LOG2);
    end
  end

  assign n_c      = prr_pkg::N_W'(1) << log2_c;
  assign shift_c  = log2_c - prr_pkg::LOG2_W'(prr_pkg::SEG_NUM_LOG2);
  assign seg_mask = (prr_pkg::ADDR_W'(1) << shift_c) - prr_pkg::ADDR_W'(1);

  // Puncture when E < N and 64K < 29E, else shorten
  assign k_scaled = prr_pkg::MUL_W'(cfg_i.info_len) * prr_pkg::MUL_W'(prr_pkg::PUNCT_K_MUL);
  assign e_scaled = prr_pkg::MUL_W'(cfg_i.rate_matched_len)
                  * prr_pkg::MUL_W'(prr_pkg::PUNCT_E_MUL);
  assign puncture = (cfg_i.rate_matched_len < prr_pkg::E_W'(n_c)) && (k_scaled < e_scaled);

  // Push: rate-matched position, then sub-block scatter
  assign take    = prr_pkg::E_W'(push_q) < cfg_i.rate_matched_len;
  assign rm_pos  = puncture
                 ? prr_pkg::E_W'(n_c) - cfg_i.rate_matched_len + prr_pkg::E_W'(push_q)
                 : prr_pkg::E_W'(push_q);
  assign rm_in   = rm_pos < prr_pkg::E_W'(n_c);
  assign rm_addr = rm_pos[prr_pkg::ADDR_W-1:0];
  assign seg_idx = prr_pkg::SEG_IDX_W'(rm_addr >> shift_c);
  assign perm_val = prr_pkg::perm_entry(cfg_i.perm, seg_idx);
  assign dst     = (prr_pkg::ADDR_W'(perm_val) << shift_c) | (rm_addr & seg_mask);

  // Pull: wrap a stale counter, flag the block end
  assign pos      = (prr_pkg::N_W'(pull_q) >= n_c) ? '0 : pull_q;
  assign pos_last = prr_pkg::N_W'(pos) == (n_c - prr_pkg::N_W'(1));
  assign fill     = puncture ? '0 : prr_pkg::LLR_W'(cfg_i.max_llr);

  // Handshake and command
  assign in_i.ready = !back_status_i.clear_busy && q_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_pull    = (in_i.func == prr_pkg::FUNC_PULL);
  assign q_valid_o  = accept && (is_pull || (take && rm_in));

  always_comb begin
    q_cmd_o.is_pull = is_pull;
    q_cmd_o.addr    = is_pull ? pos : dst;
    q_cmd_o.llr     = is_pull ? fill : in_i.llr_in;
    q_cmd_o.last    = is_pull && pos_last;
  end

  // Advance the push and pull counters
  always_comb begin
    push_d = push_q;
    pull_d = pull_q;
    if (accept) begin
      if (is_pull) begin
        if (pos_last) begin
          pull_d = '0;
          push_d = '0;
        end else begin
          pull_d = pos + prr_pkg::ADDR_W'(1);
        end
      end else if (take && (push_q != prr_pkg::PUSH_SAT)) begin
        push_d = push_q + prr_pkg::PUSH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= '0;
      pull_q <= '0;
    end else begin
      push_q <= push_d;
      pull_q <= pull_d;
    end
  end

endmodule
`default_nettype wire

### design/prr_back.sv
// Back part: clears the written flags after reset, then runs store writes and reads.
`default_nettype none
module prr_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  prr_pkg::cmd_t          q_cmd_i,
  output logic                   q_pop_o,
  output prr_pkg::back_status_t  status_o,
  prr_out_if.source              out_o
);

  typedef enum logic [2:0] {
    BK_CLEAR = 3'b001,
    BK_RUN   = 3'b010,
    BK_READ  = 3'b100
  } back_state_e;

  back_state_e                 state_q, state_d;
  logic [prr_pkg::ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  prr_pkg::cmd_t               rd_cmd_q;
  logic                        out_valid_q, out_valid_d;
  logic [prr_pkg::LLR_W-1:0]   out_llr_q;
  logic [prr_pkg::ADDR_W-1:0]  out_pos_q;
  logic                        out_last_q;

  logic                        pop_push;
  logic                        pop_pull;
  logic                        flag_we;
  logic [prr_pkg::ADDR_W-1:0]  flag_waddr;
  logic                        flag_wdata;
  logic                        flag_rdata;
  logic [prr_pkg::LLR_W-1:0]   llr_rdata;

  // Pop a push at once; pop a pull only when the output slot will be free
  always_comb begin
    q_pop_o = 1'b0;
    if ((state_q == BK_RUN) && q_valid_i) begin
      q_pop_o = !q_cmd_i.is_pull || !out_valid_q || out_o.ready;
    end
  end
  assign pop_push = q_pop_o && !q_cmd_i.is_pull;
  assign pop_pull = q_pop_o && q_cmd_i.is_pull;

  assign status_o.clear_busy = (state_q == BK_CLEAR);

  // Flag port: clearing pass, read-clear, or push set
  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = q_cmd_i.addr;
    flag_wdata = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_addr_q;
      end
      BK_READ: begin
        flag_we    = 1'b1;
        flag_waddr = rd_cmd_q.addr;
      end
      BK_RUN: begin
        flag_we    = pop_push;
        flag_wdata = 1'b1;
      end
      default: begin
        flag_we = 1'b0;
      end
    endcase
  end

  prr_ram #(
    .WIDTH (1),
    .DEPTH (prr_pkg::MAX_N)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .re_i    (pop_pull),
    .raddr_i (q_cmd_i.addr),
    .rdata_o (flag_rdata)
  );

  prr_ram #(
    .WIDTH (prr_pkg::LLR_W),
    .DEPTH (prr_pkg::MAX_N)
  ) u_llr_ram (
    .clk_i   (clk_i),
    .we_i    (pop_push),
    .waddr_i (q_cmd_i.addr),
    .wdata_i (q_cmd_i.llr),
    .re_i    (pop_pull),
    .raddr_i (q_cmd_i.addr),
    .rdata_o (llr_rdata)
  );

  // Sequence: clear sweep, then run, with a read state after each pull
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      BK_CLEAR: begin
        clr_addr_d = clr_addr_q + prr_pkg::ADDR_W'(1);
        if (clr_addr_q == prr_pkg::ADDR_W'(prr_pkg::MAX_N - 1)) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (pop_pull) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_RUN;
      end
      default: begin
        state_d = BK_CLEAR;
      end
    endcase
  end

  // Output register: load on read data, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == BK_READ) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold the pulled command and the result beat
  always_ff @(posedge clk_i) begin
    if (pop_pull) begin
      rd_cmd_q <= q_cmd_i;
    end
    if (state_q == BK_READ) begin
      out_llr_q  <= flag_rdata ? llr_rdata : rd_cmd_q.llr;
      out_pos_q  <= rd_cmd_q.addr;
      out_last_q <= rd_cmd_q.last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.llr_out  = out_llr_q;
  assign out_o.position = prr_pkg::POS_W'(out_pos_q);
  assign out_o.last     = out_last_q;

endmodule
`default_nettype wire

### design/polar_rate_recovery_deinterleave.sv
// Top level of the polar rate recovery and sub-block deinterleaving block.
`default_nettype none
// Push beats (func 0) deliver the E received LLRs of a block in arrival order;
// pull beats (func 1) read the N codeword positions back in order, one result
// beat each, with last set on position N-1. The front accepts one beat per
// cycle while its two-entry command queue has room. In the back a push is
// one write to the LLR and flag RAMs; a pull is a registered RAM read, then
// the flag clear and the load of the output register, and no new command is
// popped until that pull is through. After reset the back sweeps all 512
// entries of the written-flag RAM, one entry per cycle; no beat is accepted
// until it finishes, while configuration writes are taken throughout.
// Write configuration only while the block is idle.
module polar_rate_recovery_deinterleave (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [prr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [prr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  prr_in_if.sink                                 in_i,
  prr_out_if.source                              out_o
);

  prr_pkg::cfg_t          cfg_q, cfg_d;
  prr_pkg::back_status_t  back_status;
  logic                   fq_valid;
  prr_pkg::cmd_t          fq_cmd;
  logic                   fq_ready;
  logic                   bq_valid;
  prr_pkg::cmd_t          bq_cmd;
  logic                   bq_pop;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (prr_pkg::cfg_idx_e'(cfg_idx_i))
        prr_pkg::CFG_BLOCK_LEN_LOG2:
          cfg_d.block_len_log2 = cfg_data_i[prr_pkg::LOG2_W-1:0];
        prr_pkg::CFG_RATE_MATCHED:
          cfg_d.rate_matched_len = cfg_data_i[prr_pkg::E_W-1:0];
        prr_pkg::CFG_INFO_LEN:
          cfg_d.info_len = cfg_data_i[prr_pkg::K_W-1:0];
        prr_pkg::CFG_PERM_LOW:
          cfg_d.perm[prr_pkg::PERM_LOW_W-1:0] = cfg_data_i[prr_pkg::PERM_LOW_W-1:0];
        prr_pkg::CFG_PERM_MID:
          cfg_d.perm[prr_pkg::PERM_LOW_W +: prr_pkg::PERM_MID_W] =
            cfg_data_i[prr_pkg::PERM_MID_W-1:0];
        prr_pkg::CFG_PERM_HIGH:
          cfg_d.perm[prr_pkg::PERM_LOW_W + prr_pkg::PERM_MID_W +: prr_pkg::PERM_HIGH_W] =
            cfg_data_i[prr_pkg::PERM_HIGH_W-1:0];
        prr_pkg::CFG_MAX_LLR:
          cfg_d.max_llr = cfg_data_i[prr_pkg::MAXLLR_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= prr_pkg::CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  prr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .back_status_i (back_status),
    .in_i          (in_i),
    .q_ready_i     (fq_ready),
    .q_valid_o     (fq_valid),
    .q_cmd_o       (fq_cmd)
  );

  prr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fq_valid),
    .push_cmd_i (fq_cmd),
    .ready_o    (fq_ready),
    .pop_i      (bq_pop),
    .pop_cmd_o  (bq_cmd),
    .valid_o    (bq_valid)
  );

  prr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (bq_valid),
    .q_cmd_i   (bq_cmd),
    .q_pop_o   (bq_pop),
    .status_o  (back_status),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire
